[rtl/ordered_list_engine_top_macros.svh]
// Assertion macros for the ordered list engine.
// Included by the top level; compiled empty when SYNTHESIS is defined.
`ifndef ORDERED_LIST_ENGINE_TOP_MACROS_SVH
`define ORDERED_LIST_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define OLE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OLE_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OLE_ASSERT(label, clk, rst_n, prop, msg)
`define OLE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/ole_pkg.sv]
// Shared types and codes for the ordered list engine.
// No dependencies.
package ole_pkg;
    localparam logic [2:0] REQ_INS_HEAD = 3'd0;
    localparam logic [2:0] REQ_INS_TAIL = 3'd1;
    localparam logic [2:0] REQ_INS_POS  = 3'd2;
    localparam logic [2:0] REQ_REM_HEAD = 3'd3;
    localparam logic [2:0] REQ_REM_TAIL = 3'd4;
    localparam logic [2:0] REQ_SEARCH   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [6:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic               found;
        logic [5:0]         found_index;
        logic [6:0]         length;
    } t_rsp;
endpackage

[rtl/ordered_list_engine_top.sv]
// Ordered list engine top level: a bounded list kept in one synchronous memory.
// Depends on ole_pkg and ordered_list_engine_top_macros.svh.
//
//  channel | direction | payload        | handshake
//  request | in        | ole_pkg::t_req | i_req_valid / o_req_ready
//  result  | out       | ole_pkg::t_rsp | o_rsp_valid / i_rsp_ready
//
// The list is kept as a ring in the memory with a head pointer, so a head removal
// moves nothing. A request answered at once (full, empty or unused code) needs no state;
// an insert at the head or the tail goes straight to its write in S_DONE, a removal reads
// in S_READ and answers in S_DONE, a positional insert first moves up the elements from the
// position (a read and a write each), and a search reads until a match or the list's end.
// Reset is synchronous and clears the count and the head; the memory is not cleared.
// A request is taken only while the result register is empty or drains in that cycle.
`include "ordered_list_engine_top_macros.svh"
module ordered_list_engine_top #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ole_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ole_pkg::t_rsp o_rsp
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [2:0] {S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_SEARCH, S_READ, S_DONE}
        t_state;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    t_state                r_state;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;     // logical index being worked on
    logic [CW-1:0]         r_stop;
    logic [2:0]            r_req;
    logic [DATA_WIDTH-1:0] r_val;
    logic                  r_pend;    // a read was issued last cycle
    logic                  r_pend_last;
    logic [CW-1:0]         r_pend_idx;
    logic                  r_rsp_valid;
    ole_pkg::t_rsp         r_rsp;

    t_state                n_state;
    logic [AW-1:0]         n_head;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         n_idx;
    logic [CW-1:0]         n_stop;
    logic [2:0]            n_req;
    logic [DATA_WIDTH-1:0] n_val;
    logic                  n_pend;
    logic                  n_pend_last;
    logic [CW-1:0]         n_pend_idx;
    logic                  n_rsp_valid;
    ole_pkg::t_rsp         n_rsp;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;

    // Physical address of logical index li, relative to head h.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] li);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(li);
        if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] h);
        return (h == '0) ? AW'(CAPACITY - 1) : h - AW'(1);
    endfunction

    function automatic logic [31:0] to32(input logic [DATA_WIDTH-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    logic out_free;
    logic req_fire;
    logic rsp_stall;
    logic [DATA_WIDTH-1:0] in_val;
    assign out_free    = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE) && out_free;
    assign req_fire    = i_req_valid && o_req_ready;
    assign rsp_stall   = o_rsp_valid && !i_rsp_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign in_val      = DATA_WIDTH'($unsigned(64'($signed(i_req.value))));

    always_comb begin
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = r_val;
        mem_re = 1'b0; mem_raddr = '0;
        unique case (r_state)
            S_SHIFT_RD: begin
                // element at idx-1 moves up to idx
                mem_re = (r_idx > r_stop);
                mem_raddr = phys(r_head, r_idx - CW'(1));
            end
            S_SHIFT_WR: begin
                mem_we = 1'b1;
                mem_waddr = phys(r_head, r_idx);
                mem_wdata = r_rdata;
            end
            S_SEARCH: begin
                mem_re = (r_idx < r_count);
                mem_raddr = phys(r_head, r_idx);
            end
            S_DONE: begin
                mem_we = (r_req == ole_pkg::REQ_INS_HEAD) || (r_req == ole_pkg::REQ_INS_TAIL)
                      || (r_req == ole_pkg::REQ_INS_POS);
                mem_waddr = phys(r_head, r_stop);
            end
            S_READ: begin
                mem_re = 1'b1;
                mem_raddr = phys(r_head, r_stop);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_stop      = r_stop;
        n_req       = r_req;
        n_val       = r_val;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_pend_idx  = r_pend_idx;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_rsp       = r_rsp;
        unique case (r_state)
            S_IDLE: if (req_fire) begin
                n_req = i_req.req_type;
                n_val = in_val;
                n_rsp = '0;
                unique case (i_req.req_type)
                    ole_pkg::REQ_INS_HEAD, ole_pkg::REQ_INS_TAIL,
                    ole_pkg::REQ_INS_POS: begin
                        if (r_count == CAP) begin
                            n_rsp.status = ole_pkg::ST_FULL;
                            n_rsp.length = 7'(r_count);
                            n_rsp_valid = 1'b1;
                        end else if (i_req.req_type == ole_pkg::REQ_INS_HEAD) begin
                            n_head = dec_ptr(r_head);
                            n_stop = '0;
                            n_state = S_DONE;
                        end else if (i_req.req_type == ole_pkg::REQ_INS_TAIL ||
                                     CW'(i_req.position) >= r_count ||
                                     32'(i_req.position) > 32'(CAPACITY)) begin
                            n_stop = r_count;
                            n_state = S_DONE;
                        end else begin
                            n_stop = CW'(i_req.position);
                            n_idx = r_count;
                            n_state = S_SHIFT_RD;
                        end
                    end
                    ole_pkg::REQ_REM_HEAD, ole_pkg::REQ_REM_TAIL: begin
                        if (r_count == '0) begin
                            n_rsp.status = ole_pkg::ST_EMPTY;
                            n_rsp.length = '0;
                            n_rsp_valid = 1'b1;
                        end else begin
                            n_stop = (i_req.req_type == ole_pkg::REQ_REM_HEAD)
                                     ? '0 : r_count - CW'(1);
                            n_state = S_READ;
                        end
                    end
                    ole_pkg::REQ_SEARCH: begin
                        n_idx = '0;
                        n_state = S_SEARCH;
                    end
                    default: begin
                        n_rsp.length = 7'(r_count);
                        n_rsp_valid = 1'b1;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                if (r_idx > r_stop) n_state = S_SHIFT_WR;
                else n_state = S_DONE;
            end
            S_SHIFT_WR: begin
                n_idx = r_idx - CW'(1);
                n_state = S_SHIFT_RD;
            end
            S_READ: n_state = S_DONE;
            S_SEARCH: begin
                // compare the element read in the previous cycle
                if (r_pend && r_rdata == r_val) begin
                    n_rsp.found = 1'b1;
                    n_rsp.found_index = 6'(r_pend_idx);
                    n_rsp.length = 7'(r_count);
                    n_state = S_IDLE;
                    n_rsp_valid = 1'b1;
                end else if (r_idx >= r_count && !(r_pend && !r_pend_last)) begin
                    n_rsp.length = 7'(r_count);
                    n_state = S_IDLE;
                    n_rsp_valid = 1'b1;
                end else if (r_idx < r_count) begin
                    n_pend = 1'b1;
                    n_pend_idx = r_idx;
                    n_pend_last = (r_idx == r_count - CW'(1));
                    n_idx = r_idx + CW'(1);
                end
            end
            S_DONE: begin
                if (r_req == ole_pkg::REQ_REM_HEAD || r_req == ole_pkg::REQ_REM_TAIL) begin
                    n_rsp.removed_value = to32(r_rdata);
                    n_rsp.length = 7'(r_count - CW'(1));
                    n_count = r_count - CW'(1);
                    if (r_req == ole_pkg::REQ_REM_HEAD)
                        n_head = phys(r_head, CW'(1));
                end else begin
                    n_rsp.length = 7'(r_count + CW'(1));
                    n_count = r_count + CW'(1);
                end
                n_rsp_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_stop      <= n_stop;
        r_req       <= n_req;
        r_val       <= n_val;
        r_pend_last <= n_pend_last;
        r_pend_idx  <= n_pend_idx;
        r_rsp       <= n_rsp;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_head <= '0; r_count <= '0;
            r_rsp_valid <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
            r_pend      <= n_pend;
        end
    end

    `OLE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CAP, "element count above capacity")
    `OLE_ASSERT(a_busy_not_ready, i_clk, i_rst_n, (r_state != S_IDLE) |-> !o_req_ready, "busy")
    `OLE_ASSERT(a_rsp_held, i_clk, i_rst_n, rsp_stall |=> (o_rsp_valid && $stable(o_rsp)), "held")
    `OLE_ASSERT(a_accept_busy, i_clk, i_rst_n, req_fire |=> (!o_req_ready || o_rsp_valid), "lost")
endmodule
